### hdl/imm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer matrix multiply package
// Shared constants, register indexes and the structs that pass between the
// sequencer, the element store and the multiply-accumulate datapath.
// ----------------------------------------------------------------------------
package imm_pkg;

   localparam int MAX_DIM   = 8;
   localparam int DATA_W    = 32;
   localparam int DIM_W     = 4;
   localparam int IDX_W     = $clog2(MAX_DIM);
   localparam int ADDR_W    = $clog2(MAX_DIM * MAX_DIM);
   localparam int COUNT_W   = $clog2(MAX_DIM * MAX_DIM + 1);
   localparam int CSR_IDX_W = 2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_ROWS_A    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_DIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COLS_B    = 2'd2;

   // Tag that travels with one multiply-accumulate step down the datapath.
   typedef struct packed {
      logic             valid;
      logic             first_k;
      logic             last_k;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             last_elem;
   } tag_type;

   // Write and read requests to the element store.
   typedef struct packed {
      logic              wr_a;
      logic              wr_b;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr_a;
      logic [ADDR_W-1:0] rd_addr_b;
   } store_cmd_type;

   // Datapath status back to the sequencer.
   typedef struct packed {
      logic advance;
      logic busy;
   } mac_status_type;

   // Clamp a dimension register to the range 1 .. MAX_DIM.
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] res;
      if (v == '0) begin
         res = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         res = DIM_W'(MAX_DIM);
      end else begin
         res = v;
      end
      return res;
   endfunction

endpackage

### hdl/imm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer matrix multiply channel interfaces
// Valid/ready channels for matrix elements, result elements and register
// writes.
// ----------------------------------------------------------------------------
interface imm_req_if;
   logic               valid;
   logic               ready;
   logic               target;
   logic signed [31:0] element;

   modport source (output valid, output target, output element, input ready);
   modport sink   (input valid, input target, input element, output ready);
endinterface

interface imm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] product;
   logic [2:0]         out_row;
   logic [2:0]         out_col;
   logic               last;

   modport source (output valid, output product, output out_row, output out_col,
                   output last, input ready);
   modport sink   (input valid, input product, input out_row, input out_col,
                   input last, output ready);
endinterface

interface imm_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [3:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/imm_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer matrix multiply element store
// Two single-write, single-read memories holding the A and B matrices.
// Read data is registered and only updates while the datapath advances.
// ----------------------------------------------------------------------------
module imm_store (
   input  logic                            clock,
   input  imm_pkg::store_cmd_type          cmd,
   output logic [imm_pkg::DATA_W-1:0]      rd_a,
   output logic [imm_pkg::DATA_W-1:0]      rd_b
);
   import imm_pkg::*;

   localparam int DEPTH = MAX_DIM * MAX_DIM;

   logic [DATA_W-1:0] store_a_mem [DEPTH];
   logic [DATA_W-1:0] store_b_mem [DEPTH];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_a) begin
         store_a_mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_a_ff <= store_a_mem[cmd.rd_addr_a];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_b) begin
         store_b_mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_b_ff <= store_b_mem[cmd.rd_addr_b];
      end
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

### hdl/imm_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer matrix multiply datapath
// One shared multiplier and accumulator, pipelined as tag capture, multiply
// and accumulate, followed by the result output register.
// ----------------------------------------------------------------------------
module imm_mac (
   input  logic                       clock,
   input  logic                       reset,
   input  imm_pkg::tag_type           issue,
   input  logic [imm_pkg::DATA_W-1:0] rd_a,
   input  logic [imm_pkg::DATA_W-1:0] rd_b,
   output imm_pkg::mac_status_type    status,
   imm_rsp_if.source                  rsp_chan
);
   import imm_pkg::*;

   tag_type               s1_tag_ff;
   tag_type               s2_tag_ff;
   logic [DATA_W-1:0]     prod_ff;
   logic [DATA_W-1:0]     acc_ff;
   logic [DATA_W-1:0]     acc_in;
   logic [DATA_W-1:0]     mult_full;
   logic                  advance;
   logic                  rsp_valid_ff;
   logic [DATA_W-1:0]     rsp_product_ff;
   logic [IDX_W-1:0]      rsp_row_ff;
   logic [IDX_W-1:0]      rsp_col_ff;
   logic                  rsp_last_ff;

   // The whole pipeline holds while a finished result waits at the output.
   assign advance = !rsp_valid_ff || rsp_chan.ready;

   // The low word of the product is the same for signed and unsigned operands.
   assign mult_full = rd_a * rd_b;

   assign acc_in = (s2_tag_ff.first_k ? '0 : acc_ff) + prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff    <= '0;
         s2_tag_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
      end else if (advance) begin
         s1_tag_ff    <= issue;
         s2_tag_ff    <= s1_tag_ff;
         rsp_valid_ff <= s2_tag_ff.valid && s2_tag_ff.last_k;
         if (s2_tag_ff.valid) begin
            acc_ff <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= mult_full;
         if (s2_tag_ff.valid && s2_tag_ff.last_k) begin
            rsp_product_ff <= acc_in;
            rsp_row_ff     <= s2_tag_ff.row;
            rsp_col_ff     <= s2_tag_ff.col;
            rsp_last_ff    <= s2_tag_ff.last_elem;
         end
      end
   end

   assign status.advance   = advance;
   assign status.busy      = s1_tag_ff.valid || s2_tag_ff.valid || rsp_valid_ff;

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.product = rsp_product_ff;
   assign rsp_chan.out_row = rsp_row_ff;
   assign rsp_chan.out_col = rsp_col_ff;
   assign rsp_chan.last    = rsp_last_ff;

endmodule

### hdl/imm_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer matrix multiply sequencer
// Holds the dimension registers and load counters, writes incoming elements
// into the store and walks row, column and inner index during the multiply.
// ----------------------------------------------------------------------------
module imm_seq (
   input  logic                          clock,
   input  logic                          reset,
   imm_req_if.sink                       req_chan,
   imm_csr_if.sink                       csr_chan,
   input  imm_pkg::mac_status_type       status,
   output imm_pkg::store_cmd_type        cmd,
   output imm_pkg::tag_type              issue
);
   import imm_pkg::*;

   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]         state_ff,   state_in;
   logic [DIM_W-1:0]   rows_a_ff,  rows_a_in;
   logic [DIM_W-1:0]   inner_ff,   inner_in;
   logic [DIM_W-1:0]   cols_b_ff,  cols_b_in;
   logic [COUNT_W-1:0] count_a_ff, count_a_in;
   logic [COUNT_W-1:0] count_b_ff, count_b_in;
   logic [IDX_W-1:0]   r_ff, r_in;
   logic [IDX_W-1:0]   c_ff, c_in;
   logic [IDX_W-1:0]   k_ff, k_in;
   logic [ADDR_W-1:0]  base_a_ff, base_a_in;
   logic [ADDR_W-1:0]  addr_a_ff, addr_a_in;
   logic [ADDR_W-1:0]  addr_b_ff, addr_b_in;

   logic [DIM_W-1:0]   nr, nk, nc;
   logic [DIM_W-1:0]   nr_m1, nk_m1, nc_m1;
   logic [2*DIM_W-1:0] size_a_full, size_b_full;
   logic [COUNT_W-1:0] size_a, size_b;
   logic [COUNT_W-1:0] idx_a, idx_b, inc_a, inc_b;
   logic               req_take, csr_take, csr_hit;
   logic               k_end, c_end, r_end;
   logic [ADDR_W-1:0]  base_a_next;

   assign nr    = eff_dim(rows_a_ff);
   assign nk    = eff_dim(inner_ff);
   assign nc    = eff_dim(cols_b_ff);
   assign nr_m1 = nr - DIM_W'(1);
   assign nk_m1 = nk - DIM_W'(1);
   assign nc_m1 = nc - DIM_W'(1);

   assign size_a_full = {{DIM_W{1'b0}}, nr} * {{DIM_W{1'b0}}, nk};
   assign size_b_full = {{DIM_W{1'b0}}, nk} * {{DIM_W{1'b0}}, nc};
   assign size_a      = size_a_full[COUNT_W-1:0];
   assign size_b      = size_b_full[COUNT_W-1:0];

   assign idx_a = (count_a_ff >= size_a) ? '0 : count_a_ff;
   assign idx_b = (count_b_ff >= size_b) ? '0 : count_b_ff;
   assign inc_a = idx_a + COUNT_W'(1);
   assign inc_b = idx_b + COUNT_W'(1);

   assign req_chan.ready = (state_ff == ST_LOAD);
   assign csr_chan.ready = 1'b1;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign csr_take       = csr_chan.valid && csr_chan.ready;
   assign csr_hit        = csr_take && (csr_chan.index == REG_ROWS_A ||
                                        csr_chan.index == REG_INNER_DIM ||
                                        csr_chan.index == REG_COLS_B);

   assign k_end       = ({1'b0, k_ff} == nk_m1);
   assign c_end       = ({1'b0, c_ff} == nc_m1);
   assign r_end       = ({1'b0, r_ff} == nr_m1);
   assign base_a_next = base_a_ff + ADDR_W'(nk);

   // Store write and read requests.
   always_comb begin
      cmd.wr_a      = req_take && !req_chan.target;
      cmd.wr_b      = req_take && req_chan.target;
      cmd.wr_addr   = req_chan.target ? idx_b[ADDR_W-1:0] : idx_a[ADDR_W-1:0];
      cmd.wr_data   = req_chan.element;
      cmd.rd_en     = status.advance;
      cmd.rd_addr_a = addr_a_ff;
      cmd.rd_addr_b = addr_b_ff;
   end

   always_comb begin
      issue.valid     = (state_ff == ST_RUN);
      issue.first_k   = (k_ff == '0);
      issue.last_k    = k_end;
      issue.row       = r_ff;
      issue.col       = c_ff;
      issue.last_elem = r_end && c_end;
   end

   always_comb begin
      state_in   = state_ff;
      rows_a_in  = rows_a_ff;
      inner_in   = inner_ff;
      cols_b_in  = cols_b_ff;
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      r_in       = r_ff;
      c_in       = c_ff;
      k_in       = k_ff;
      base_a_in  = base_a_ff;
      addr_a_in  = addr_a_ff;
      addr_b_in  = addr_b_ff;

      if (csr_hit) begin
         unique case (csr_chan.index)
            REG_ROWS_A:    rows_a_in = csr_chan.data;
            REG_INNER_DIM: inner_in  = csr_chan.data;
            REG_COLS_B:    cols_b_in = csr_chan.data;
            default:       ;
         endcase
         count_a_in = '0;
         count_b_in = '0;
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (req_take && !req_chan.target) begin
               count_a_in = (inc_a >= size_a) ? '0 : inc_a;
            end else if (req_take && req_chan.target) begin
               if (inc_b >= size_b) begin
                  count_b_in = '0;
                  state_in   = ST_RUN;
                  r_in       = '0;
                  c_in       = '0;
                  k_in       = '0;
                  base_a_in  = '0;
                  addr_a_in  = '0;
                  addr_b_in  = '0;
               end else begin
                  count_b_in = inc_b;
               end
            end
         end
         ST_RUN: begin
            if (status.advance) begin
               if (!k_end) begin
                  k_in      = k_ff + IDX_W'(1);
                  addr_a_in = addr_a_ff + ADDR_W'(1);
                  addr_b_in = addr_b_ff + ADDR_W'(nc);
               end else if (!c_end) begin
                  k_in      = '0;
                  c_in      = c_ff + IDX_W'(1);
                  addr_a_in = base_a_ff;
                  addr_b_in = ADDR_W'(c_ff) + ADDR_W'(1);
               end else if (!r_end) begin
                  k_in      = '0;
                  c_in      = '0;
                  r_in      = r_ff + IDX_W'(1);
                  base_a_in = base_a_next;
                  addr_a_in = base_a_next;
                  addr_b_in = '0;
               end else begin
                  state_in  = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (!status.busy) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         rows_a_ff  <= DIM_W'(1);
         inner_ff   <= DIM_W'(1);
         cols_b_ff  <= DIM_W'(1);
         count_a_ff <= '0;
         count_b_ff <= '0;
         r_ff       <= '0;
         c_ff       <= '0;
         k_ff       <= '0;
         base_a_ff  <= '0;
         addr_a_ff  <= '0;
         addr_b_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         rows_a_ff  <= rows_a_in;
         inner_ff   <= inner_in;
         cols_b_ff  <= cols_b_in;
         count_a_ff <= count_a_in;
         count_b_ff <= count_b_in;
         r_ff       <= r_in;
         c_ff       <= c_in;
         k_ff       <= k_in;
         base_a_ff  <= base_a_in;
         addr_a_ff  <= addr_a_in;
         addr_b_ff  <= addr_b_in;
      end
   end

endmodule

### hdl/integer_matrix_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer matrix multiply
// Multiplies a loaded A matrix by a loaded B matrix of signed 32-bit
// integers with one shared multiply-accumulate unit.
//
// Channel  Direction  Transaction carries
// req_     in         target (0 = A, 1 = B), element
// rsp_     out        product, out_row, out_col, last
// csr_     in         index (0 rows_a, 1 inner_dim, 2 cols_b), data
//
// Elements are accepted only while loading. The transaction that completes
// B starts the multiply: one multiply-accumulate per cycle through the
// shared multiplier while no result is stalled; req_ready returns once the
// last result has left the read, multiply, accumulate and output registers.
// A stalled result holds the whole datapath. Reset is synchronous; it sets
// all three dimensions to one and clears the load positions. The element
// memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module integer_matrix_multiply (
   input  logic      clock,
   input  logic      reset,
   imm_req_if.sink   req_chan,
   imm_rsp_if.source rsp_chan,
   imm_csr_if.sink   csr_chan
);
   import imm_pkg::*;

   store_cmd_type     cmd;
   tag_type           issue;
   mac_status_type    status;
   logic [DATA_W-1:0] rd_a;
   logic [DATA_W-1:0] rd_b;

   // The sequencer owns the dimension registers, the load positions and the
   // row, column and inner-index walk of the multiply.
   imm_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .csr_chan (csr_chan),
      .status   (status),
      .cmd      (cmd),
      .issue    (issue)
   );

   // Both matrices live in memories with registered read data.
   imm_store u_store (
      .clock (clock),
      .cmd   (cmd),
      .rd_a  (rd_a),
      .rd_b  (rd_b)
   );

   // The shared multiplier and accumulator, plus the result register.
   imm_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .issue    (issue),
      .rd_a     (rd_a),
      .rd_b     (rd_b),
      .status   (status),
      .rsp_chan (rsp_chan)
   );

endmodule

### bench/imm_product_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer matrix multiply product checker
// Tracks the dimension registers and both element stores from the observed
// transactions. It computes every product element that the block owes and
// compares each result transaction with the oldest one still owed.
// ----------------------------------------------------------------------------
module imm_product_checker (
   input  logic clock,
   input  logic reset,
   imm_req_if   req_mon,
   imm_rsp_if   rsp_mon,
   imm_csr_if   csr_mon,
   output int   failures,
   output int   pending
);
   import imm_pkg::*;

   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;

   typedef struct packed {
      logic [DATA_W-1:0] product;
      logic [2:0]        row;
      logic [2:0]        col;
      logic              last;
   } product_elem_type;

   logic [DIM_W-1:0]  rows_reg;
   logic [DIM_W-1:0]  inner_reg;
   logic [DIM_W-1:0]  cols_reg;
   logic [DATA_W-1:0] a_words [STORE_DEPTH];
   logic [DATA_W-1:0] b_words [STORE_DEPTH];
   int unsigned       a_fill;
   int unsigned       b_fill;
   product_elem_type  owed_products [$];

   // Dimension as the block uses it: zero acts as one, large values saturate.
   function automatic int unsigned span(input logic [DIM_W-1:0] raw);
      int unsigned n;
      n = raw;
      if (n == 0) begin
         n = 1;
      end else if (n > MAX_DIM) begin
         n = MAX_DIM;
      end
      return n;
   endfunction

   task automatic compute_products();
      int unsigned      nr;
      int unsigned      nk;
      int unsigned      nc;
      logic [DATA_W-1:0] acc;
      product_elem_type elem;
      nr = span(rows_reg);
      nk = span(inner_reg);
      nc = span(cols_reg);
      for (int unsigned r = 0; r < nr; r++) begin
         for (int unsigned c = 0; c < nc; c++) begin
            acc = '0;
            for (int unsigned k = 0; k < nk; k++) begin
               acc = acc + a_words[r * nk + k] * b_words[k * nc + c];
            end
            elem.product = acc;
            elem.row     = 3'(r);
            elem.col     = 3'(c);
            elem.last    = (r == nr - 1) && (c == nc - 1);
            owed_products.push_back(elem);
         end
      end
   endtask

   task automatic store_element(input logic to_b, input logic [DATA_W-1:0] value);
      int unsigned size;
      if (!to_b) begin
         size = span(rows_reg) * span(inner_reg);
         if (a_fill >= size) begin
            a_fill = 0;
         end
         a_words[a_fill] = value;
         a_fill++;
         if (a_fill >= size) begin
            a_fill = 0;
         end
      end else begin
         size = span(inner_reg) * span(cols_reg);
         if (b_fill >= size) begin
            b_fill = 0;
         end
         b_words[b_fill] = value;
         b_fill++;
         // The element that completes B starts the multiply.
         if (b_fill >= size) begin
            b_fill = 0;
            compute_products();
         end
      end
   endtask

   task automatic apply_write(input logic [CSR_IDX_W-1:0] index,
                              input logic [DIM_W-1:0] value);
      logic known;
      known = 1'b1;
      case (index)
         REG_ROWS_A: begin
            rows_reg = value;
         end
         REG_INNER_DIM: begin
            inner_reg = value;
         end
         REG_COLS_B: begin
            cols_reg = value;
         end
         default: begin
            known = 1'b0;
         end
      endcase
      if (known) begin
         a_fill = 0;
         b_fill = 0;
      end
   endtask

   task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                                input logic [DATA_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h", $time, name, want, got);
         failures++;
      end
   endtask

   task automatic check_product();
      product_elem_type want;
      if (owed_products.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual product 'h%0h row %0d col %0d",
                  $time, rsp_mon.product, rsp_mon.out_row, rsp_mon.out_col);
         failures++;
      end else begin
         want = owed_products.pop_front();
         compare_field("product", want.product, rsp_mon.product);
         compare_field("out_row", DATA_W'(want.row), DATA_W'(rsp_mon.out_row));
         compare_field("out_col", DATA_W'(want.col), DATA_W'(rsp_mon.out_col));
         compare_field("last", DATA_W'(want.last), DATA_W'(rsp_mon.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rows_reg  = DIM_W'(1);
         inner_reg = DIM_W'(1);
         cols_reg  = DIM_W'(1);
         a_fill    = 0;
         b_fill    = 0;
         owed_products.delete();
      end else begin
         // A result can never come at the same edge as the element that causes it.
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_product();
         end
         if (csr_mon.valid && csr_mon.ready) begin
            apply_write(csr_mon.index, csr_mon.data);
         end
         if (req_mon.valid && req_mon.ready) begin
            store_element(req_mon.target, req_mon.element);
         end
      end
      pending = owed_products.size();
   end

endmodule

### bench/integer_matrix_multiply_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer matrix multiply testbench
// Loads A and B matrices of random and extreme elements under a range of
// dimension settings and handshake pressure. A separate checker predicts
// every product element and compares it with what the block returns.
// ----------------------------------------------------------------------------
module integer_matrix_multiply_tb;
   import imm_pkg::*;

   typedef enum logic {
      MAT_A = 1'b0,
      MAT_B = 1'b1
   } matrix_sel_type;

   // Index past the register list; a write there must leave everything alone.
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 9;
   // Once the last result is taken the block still has to leave its drain state
   // to return to loading; these idle cycles leave ample margin for that.
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 4000;
   localparam int RANDOM_ITEMS  = 350;
   localparam int PHASES        = 4;

   logic clock = 1'b0;
   logic reset = 1'b1;

   imm_req_if req_bus ();
   imm_rsp_if rsp_bus ();
   imm_csr_if csr_bus ();

   int failures;
   int pending;

   // Handshake pressure of the current phase, in percent of cycles.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // Stimulus-side view of the block. It only keeps the generator from
   // completing B while some A entry that the multiply reads is unwritten.
   logic [DIM_W-1:0]           rows_val  = DIM_W'(1);
   logic [DIM_W-1:0]           inner_val = DIM_W'(1);
   logic [DIM_W-1:0]           cols_val  = DIM_W'(1);
   int unsigned                a_pos     = 0;
   int unsigned                b_pos     = 0;
   logic [MAX_DIM*MAX_DIM-1:0] a_loaded  = '0;
   logic [DIM_W-1:0]           reg_vals [4];

   int unsigned items_sent   = 0;
   int unsigned quiet_cycles = 0;

   integer_matrix_multiply dut (
      .clock,
      .reset,
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   imm_product_checker product_check (
      .clock,
      .reset,
      .req_mon  (req_bus),
      .rsp_mon  (rsp_bus),
      .csr_mon  (csr_bus),
      .failures (failures),
      .pending  (pending)
   );

   always begin
      #HALF_PERIOD clock = ~clock;
   end

   // The result side stalls independently each cycle at the phase's rate.
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic int unsigned a_size();
      return 32'(eff_dim(rows_val)) * 32'(eff_dim(inner_val));
   endfunction

   function automatic int unsigned b_size();
      return 32'(eff_dim(inner_val)) * 32'(eff_dim(cols_val));
   endfunction

   // True once every A entry that the next multiply reads has been written.
   function automatic logic a_complete();
      logic ok;
      ok = 1'b1;
      for (int unsigned i = 0; i < a_size(); i++) begin
         if (!a_loaded[i]) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   // Half fully random words, the rest small values around zero and the
   // extremes of the signed range, where wraparound shows up.
   function automatic logic [DATA_W-1:0] random_element();
      logic [DATA_W-1:0] v;
      case ($urandom_range(3))
         0: begin
            v = DATA_W'($urandom_range(16)) - DATA_W'(8);
         end
         1: begin
            case ($urandom_range(4))
               0: begin
                  v = 32'h8000_0000;
               end
               1: begin
                  v = 32'h7FFF_FFFF;
               end
               2: begin
                  v = '1;
               end
               3: begin
                  v = 32'h8000_0001;
               end
               default: begin
                  v = '0;
               end
            endcase
         end
         default: begin
            v = $urandom;
         end
      endcase
      return v;
   endfunction

   // Mostly small dimensions; the largest and out-of-range values now and then.
   function automatic logic [DIM_W-1:0] random_dim();
      logic [DIM_W-1:0] v;
      int unsigned      pick;
      pick = $urandom_range(9);
      if (pick < 6) begin
         v = DIM_W'($urandom_range(3, 1));
      end else if (pick < 8) begin
         v = DIM_W'($urandom_range(MAX_DIM, 4));
      end else if (pick < 9) begin
         v = DIM_W'(MAX_DIM);
      end else if ($urandom_range(1) == 0) begin
         v = '0;
      end else begin
         v = DIM_W'($urandom_range(15, MAX_DIM + 1));
      end
      return v;
   endfunction

   // Offers one element and holds it until accepted. Valid stays high on
   // return so that back-to-back transactions need no gap; settle() drops it.
   task automatic push_element(input matrix_sel_type sel, input logic [DATA_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.target  <= sel;
      req_bus.element <= value;
      do @(posedge clock); while (!req_bus.ready);
      if (sel == MAT_A) begin
         a_loaded[a_pos] = 1'b1;
         a_pos++;
         if (a_pos >= a_size()) begin
            a_pos = 0;
         end
      end else begin
         b_pos++;
         if (b_pos >= b_size()) begin
            b_pos = 0;
         end
      end
      items_sent++;
   endtask

   // Before the element that would complete B, A elements of random content
   // are slipped in until every A entry the multiply reads has been written.
   task automatic load_element(input matrix_sel_type sel, input logic [DATA_W-1:0] value);
      while (sel == MAT_B && b_pos + 1 == b_size() && !a_complete()) begin
         push_element(MAT_A, random_element());
      end
      push_element(sel, value);
   endtask

   // Loads the rest of one matrix from the current load position.
   task automatic load_matrix(input matrix_sel_type sel);
      int unsigned remaining;
      remaining = (sel == MAT_A) ? a_size() - a_pos : b_size() - b_pos;
      repeat (remaining) begin
         load_element(sel, random_element());
      end
   endtask

   // Drops the element valid and waits until the block owes nothing and has
   // had time to drain. Pending is sampled on the falling edge, after the
   // checker has taken the rising edge into account.
   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the registers selected in the mask with the values in reg_vals,
   // lowest index first, then drops the write valid.
   task automatic write_regs(input logic [3:0] mask);
      logic [CSR_IDX_W-1:0] index;
      for (int i = 0; i < 4; i++) begin
         if (mask[i]) begin
            index = CSR_IDX_W'(i);
            csr_bus.valid <= 1'b1;
            csr_bus.index <= index;
            csr_bus.data  <= reg_vals[i];
            do @(posedge clock); while (!csr_bus.ready);
            if (index != REG_UNUSED) begin
               case (index)
                  REG_ROWS_A: begin
                     rows_val = reg_vals[i];
                  end
                  REG_INNER_DIM: begin
                     inner_val = reg_vals[i];
                  end
                  default: begin
                     cols_val = reg_vals[i];
                  end
               endcase
               a_pos = 0;
               b_pos = 0;
            end
         end
      end
      csr_bus.valid <= 1'b0;
   endtask

   // One round of random traffic. Most rounds load well-formed A and B
   // matrices; some reuse the loaded A with a fresh B, and the rest are a
   // short burst of elements for either matrix that may leave loads half done.
   task automatic random_round();
      int unsigned style;
      style = $urandom_range(9);
      if (style < 6) begin
         load_matrix(MAT_A);
         load_matrix(MAT_B);
      end else if (style < 8) begin
         load_matrix(MAT_B);
      end else begin
         repeat ($urandom_range(12, 1)) begin
            load_element(matrix_sel_type'($urandom_range(1)), random_element());
         end
      end
   endtask

   // The watchdog ends the run if no transaction of any kind is accepted
   // for too long, which also catches results that never arrive.
   initial begin
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("integer_matrix_multiply_tb failed");
      $finish;
   end

   initial begin
      req_bus.valid   <= 1'b0;
      req_bus.target  <= MAT_A;
      req_bus.element <= '0;
      csr_bus.valid   <= 1'b0;
      csr_bus.index   <= REG_ROWS_A;
      csr_bus.data    <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the reset dimensions of one by one: products at the
      // signed extremes, a B element that reuses the loaded A, and A elements
      // that overwrite A from the start once it is full.
      load_element(MAT_A, 32'h7FFF_FFFF);
      load_element(MAT_B, 32'h7FFF_FFFF);
      load_element(MAT_A, 32'h8000_0000);
      load_element(MAT_B, 32'h8000_0000);
      load_element(MAT_A, '1);
      load_element(MAT_B, 32'h8000_0001);
      load_element(MAT_B, 32'h0000_0003);
      load_element(MAT_A, 32'h1234_5678);
      load_element(MAT_A, 32'hFFFF_FFFE);
      load_element(MAT_B, '0);
      settle();

      // Out-of-range dimensions: a row count above the maximum saturates and
      // an inner dimension of zero acts as one, so A is a column of eight.
      reg_vals[REG_ROWS_A]    = 4'hF;
      reg_vals[REG_INNER_DIM] = 4'h0;
      reg_vals[REG_COLS_B]    = 4'h1;
      write_regs(4'b0111);
      load_element(MAT_A, 32'h8000_0000);
      load_element(MAT_A, 32'h7FFF_FFFF);
      load_element(MAT_A, 32'h0000_0001);
      settle();

      // A write past the register list must not restart the half-loaded A.
      reg_vals[REG_UNUSED] = DIM_W'($urandom);
      write_regs(4'b1000);
      load_element(MAT_A, '1);
      load_element(MAT_A, 32'hFFFF_FFF9);
      load_element(MAT_A, 32'h0000_0000);
      load_element(MAT_A, 32'h5555_5555);
      load_element(MAT_A, 32'hAAAA_AAAA);
      load_element(MAT_B, 32'h8000_0001);

      // Random part, in phases of different handshake pressure. Every round
      // first lets the block go idle and then rewrites a random subset of
      // the registers, which restarts both loads when a dimension is written.
      for (int phase = 0; phase < PHASES; phase++) begin
         int unsigned goal;
         goal = items_sent + RANDOM_ITEMS / PHASES;
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 67;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 67;
            end
            default: begin
               send_idle_pct  = 11;
               recv_stall_pct = 11;
            end
         endcase
         while (items_sent < goal) begin
            settle();
            for (int i = 0; i < 4; i++) begin
               reg_vals[i] = random_dim();
            end
            write_regs(4'($urandom_range(15)));
            random_round();
         end
      end

      settle();
      if (failures == 0) begin
         $display("integer_matrix_multiply_tb passed");
      end else begin
         $display("integer_matrix_multiply_tb failed");
      end
      $finish;
   end

endmodule
